// ----- rtl/dcvs_pkg.sv -----
// Shared types, constants and saturation helper for the distance constraint solver.
package dcvs_pkg;

    localparam int unsigned SQRT_STEPS = 32;
    localparam int unsigned NDIV_STEPS = 17;
    localparam int unsigned LDIV_STEPS = 32;

    localparam logic [30:0] ITS_RESET = 31'd15728640;

    localparam logic CFG_REST_LENGTH = 1'b0;
    localparam logic CFG_INV_TIME_STEP = 1'b1;

    typedef logic [2:0][31:0] t_vec3;
    typedef logic [2:0][17:0] t_nvec;

    typedef struct packed {
        t_vec3       va;
        t_vec3       vb;
        logic [30:0] wa;
        logic [30:0] wb;
        logic        degen;
    } t_vel;

    function automatic logic signed [31:0] sat32(input logic signed [63:0] x);
        logic signed [31:0] res;
        if (x > 64'sd2147483647) begin
            res = 32'sh7fffffff;
        end else if (x < -64'sd2147483648) begin
            res = 32'sh80000000;
        end else begin
            res = x[31:0];
        end
        return res;
    endfunction

endpackage

// ----- rtl/distance_constraint_velocity_solve.sv -----
// Distance constraint velocity solver: top level with configuration registers.
// One constraint is taken on every cycle that start is high; busy is never raised.
// Each result shows on the o_new_vel_* and o_degenerate ports for one cycle, marked
// by o_done, in input order. The pipeline holds the 32-stage square root, the
// 17-stage direction divider and the 32-stage impulse divider, one result bit per
// stage each. The receiver cannot stall the block, so results must be taken on the
// cycle they appear. Registers are written through i_cfg_we/i_cfg_idx/i_cfg_wdata
// and should change only while no item is in flight.
module distance_constraint_velocity_solve (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        start,
    output logic        busy,
    input  logic        i_cfg_we,
    input  logic        i_cfg_idx,
    input  logic [30:0] i_cfg_wdata,
    input  logic [31:0] i_delta_x,
    input  logic [31:0] i_delta_y,
    input  logic [31:0] i_delta_z,
    input  logic [31:0] i_vel_a_x,
    input  logic [31:0] i_vel_a_y,
    input  logic [31:0] i_vel_a_z,
    input  logic [31:0] i_vel_b_x,
    input  logic [31:0] i_vel_b_y,
    input  logic [31:0] i_vel_b_z,
    input  logic [30:0] i_inv_mass_a,
    input  logic [30:0] i_inv_mass_b,
    output logic        o_done,
    output logic [31:0] o_new_vel_a_x,
    output logic [31:0] o_new_vel_a_y,
    output logic [31:0] o_new_vel_a_z,
    output logic [31:0] o_new_vel_b_x,
    output logic [31:0] o_new_vel_b_y,
    output logic [31:0] o_new_vel_b_z,
    output logic        o_degenerate
);

    logic [30:0]     r_rest_length;
    logic [30:0]     r_inv_time_step;

    dcvs_pkg::t_vec3 in_d;
    dcvs_pkg::t_vel  in_vel;

    logic            nrm_vld;
    logic [31:0]     nrm_len;
    dcvs_pkg::t_nvec nrm_n;
    dcvs_pkg::t_vel  nrm_vel;

    logic            imp_vld;
    logic [31:0]     imp_lam;
    dcvs_pkg::t_nvec imp_n;
    dcvs_pkg::t_vel  imp_vel;

    dcvs_pkg::t_vec3 out_va;
    dcvs_pkg::t_vec3 out_vb;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rest_length   <= '0;
            r_inv_time_step <= dcvs_pkg::ITS_RESET;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                dcvs_pkg::CFG_REST_LENGTH:   r_rest_length   <= i_cfg_wdata;
                dcvs_pkg::CFG_INV_TIME_STEP: r_inv_time_step <= i_cfg_wdata;
                default: ;
            endcase
        end
    end

    assign busy = 1'b0;

    assign in_d         = {i_delta_z, i_delta_y, i_delta_x};
    assign in_vel.va    = {i_vel_a_z, i_vel_a_y, i_vel_a_x};
    assign in_vel.vb    = {i_vel_b_z, i_vel_b_y, i_vel_b_x};
    assign in_vel.wa    = i_inv_mass_a;
    assign in_vel.wb    = i_inv_mass_b;
    assign in_vel.degen = ~(|{i_inv_mass_a, i_inv_mass_b});

    dcvs_norm u_norm (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (start & ~busy),
        .i_d     (in_d),
        .i_vel   (in_vel),
        .o_valid (nrm_vld),
        .o_len   (nrm_len),
        .o_n     (nrm_n),
        .o_vel   (nrm_vel)
    );

    dcvs_impulse u_impulse (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_valid         (nrm_vld),
        .i_len           (nrm_len),
        .i_n             (nrm_n),
        .i_vel           (nrm_vel),
        .i_rest_length   (r_rest_length),
        .i_inv_time_step (r_inv_time_step),
        .o_valid         (imp_vld),
        .o_lam           (imp_lam),
        .o_n             (imp_n),
        .o_vel           (imp_vel)
    );

    dcvs_apply u_apply (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (imp_vld),
        .i_lam   (imp_lam),
        .i_n     (imp_n),
        .i_vel   (imp_vel),
        .o_valid (o_done),
        .o_va    (out_va),
        .o_vb    (out_vb),
        .o_degen (o_degenerate)
    );

    assign o_new_vel_a_x = out_va[0];
    assign o_new_vel_a_y = out_va[1];
    assign o_new_vel_a_z = out_va[2];
    assign o_new_vel_b_x = out_vb[0];
    assign o_new_vel_b_y = out_vb[1];
    assign o_new_vel_b_z = out_vb[2];

endmodule

// ----- rtl/dcvs_norm.sv -----
// Separation (pipelined square root) and unit direction (pipelined division).
module dcvs_norm (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_valid,
    input  dcvs_pkg::t_vec3 i_d,
    input  dcvs_pkg::t_vel  i_vel,
    output logic           o_valid,
    output logic [31:0]    o_len,
    output dcvs_pkg::t_nvec o_n,
    output dcvs_pkg::t_vel  o_vel
);

    localparam int unsigned SQ = dcvs_pkg::SQRT_STEPS;
    localparam int unsigned ND = dcvs_pkg::NDIV_STEPS;

    typedef struct packed {
        dcvs_pkg::t_vec3 mag;
        logic [2:0]      neg;
        dcvs_pkg::t_vel  vel;
    } t_side;

    logic                  r_a_vld;
    t_side                 r_a_side;
    logic                  r_b_vld;
    logic [2:0][63:0]      r_b_sq;
    t_side                 r_b_side;
    logic                  r_c_vld;
    logic [63:0]           r_c_sum;
    t_side                 r_c_side;

    logic                  r_s_vld  [SQ];
    logic [33:0]           r_s_rem  [SQ];
    logic [31:0]           r_s_root [SQ];
    logic [63:0]           r_s_v    [SQ];
    t_side                 r_s_side [SQ];

    logic                  r_q_vld  [ND];
    dcvs_pkg::t_vec3       r_q_rem  [ND];
    logic [2:0][16:0]      r_q_quo  [ND];
    logic [31:0]           r_q_len  [ND];
    t_side                 r_q_side [ND];

    logic                  r_o_vld;
    logic [31:0]           r_o_len;
    dcvs_pkg::t_nvec       r_o_n;
    dcvs_pkg::t_vel        r_o_vel;

    t_side                 side_in;

    always_comb begin
        side_in.vel = i_vel;
        for (int i = 0; i < 3; i++) begin
            side_in.neg[i] = i_d[i][31];
            side_in.mag[i] = i_d[i][31] ? 32'(-i_d[i]) : i_d[i];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_vld <= 1'b0;
            r_b_vld <= 1'b0;
            r_c_vld <= 1'b0;
            r_o_vld <= 1'b0;
        end else begin
            r_a_vld <= i_valid;
            r_b_vld <= r_a_vld;
            r_c_vld <= r_b_vld;
            r_o_vld <= r_q_vld[ND-1];
        end
    end

    always_ff @(posedge i_clk) begin
        r_a_side <= side_in;
        for (int i = 0; i < 3; i++) begin
            r_b_sq[i] <= r_a_side.mag[i] * r_a_side.mag[i];
        end
        r_b_side <= r_a_side;
        r_c_sum  <= r_b_sq[0] + r_b_sq[1] + r_b_sq[2];
        r_c_side <= r_b_side;
    end

    // square root, one result bit per stage
    genvar k;
    for (k = 0; k < SQ; k++) begin : g_sq
        logic        vld_in;
        logic [33:0] rem_in;
        logic [31:0] root_in;
        logic [63:0] v_in;
        t_side       sd_in;
        logic [35:0] cat;
        logic [35:0] trial;

        if (k == 0) begin : g_first
            assign vld_in  = r_c_vld;
            assign rem_in  = '0;
            assign root_in = '0;
            assign v_in    = r_c_sum;
            assign sd_in   = r_c_side;
        end else begin : g_next
            assign vld_in  = r_s_vld[k-1];
            assign rem_in  = r_s_rem[k-1];
            assign root_in = r_s_root[k-1];
            assign v_in    = r_s_v[k-1];
            assign sd_in   = r_s_side[k-1];
        end

        assign cat   = {rem_in, v_in[2*(SQ-1-k)+1 -: 2]};
        assign trial = {2'b00, root_in, 2'b01};

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_s_vld[k] <= 1'b0;
            end else begin
                r_s_vld[k] <= vld_in;
            end
        end

        always_ff @(posedge i_clk) begin
            if (cat >= trial) begin
                r_s_rem[k]  <= 34'(cat - trial);
                r_s_root[k] <= {root_in[30:0], 1'b1};
            end else begin
                r_s_rem[k]  <= 34'(cat);
                r_s_root[k] <= {root_in[30:0], 1'b0};
            end
            r_s_v[k]    <= v_in;
            r_s_side[k] <= sd_in;
        end
    end

    // direction magnitude |d| * 2^16 / len, one quotient bit per stage
    genvar j;
    for (j = 0; j < ND; j++) begin : g_nd
        logic             vld_in;
        dcvs_pkg::t_vec3  rem_in;
        logic [2:0]       bit_in;
        logic [2:0][16:0] quo_in;
        logic [31:0]      len_in;
        t_side            sd_in;
        logic [2:0][32:0] cat;

        if (j == 0) begin : g_first
            always_comb begin
                vld_in = r_s_vld[SQ-1];
                len_in = r_s_root[SQ-1];
                sd_in  = r_s_side[SQ-1];
                sd_in.vel.degen = r_s_side[SQ-1].vel.degen | (r_s_root[SQ-1] == 32'd0);
                quo_in = '0;
                for (int i = 0; i < 3; i++) begin
                    rem_in[i] = {1'b0, r_s_side[SQ-1].mag[i][31:1]};
                    bit_in[i] = r_s_side[SQ-1].mag[i][0];
                end
            end
        end else begin : g_next
            assign vld_in = r_q_vld[j-1];
            assign len_in = r_q_len[j-1];
            assign sd_in  = r_q_side[j-1];
            assign quo_in = r_q_quo[j-1];
            assign rem_in = r_q_rem[j-1];
            assign bit_in = '0;
        end

        always_comb begin
            for (int i = 0; i < 3; i++) begin
                cat[i] = {rem_in[i], bit_in[i]};
            end
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_q_vld[j] <= 1'b0;
            end else begin
                r_q_vld[j] <= vld_in;
            end
        end

        always_ff @(posedge i_clk) begin
            for (int i = 0; i < 3; i++) begin
                if (cat[i] >= {1'b0, len_in}) begin
                    r_q_rem[j][i] <= 32'(cat[i] - {1'b0, len_in});
                    r_q_quo[j][i] <= {quo_in[i][15:0], 1'b1};
                end else begin
                    r_q_rem[j][i] <= 32'(cat[i]);
                    r_q_quo[j][i] <= {quo_in[i][15:0], 1'b0};
                end
            end
            r_q_len[j]  <= len_in;
            r_q_side[j] <= sd_in;
        end
    end

    always_ff @(posedge i_clk) begin
        for (int i = 0; i < 3; i++) begin
            r_o_n[i] <= r_q_side[ND-1].neg[i] ? 18'(-{1'b0, r_q_quo[ND-1][i]})
                                              : {1'b0, r_q_quo[ND-1][i]};
        end
        r_o_len <= r_q_len[ND-1];
        r_o_vel <= r_q_side[ND-1].vel;
    end

    assign o_valid = r_o_vld;
    assign o_len   = r_o_len;
    assign o_n     = r_o_n;
    assign o_vel   = r_o_vel;

endmodule

// ----- rtl/dcvs_impulse.sv -----
// Relative velocity, Baumgarte bias and impulse (pipelined division by wa + wb).
module dcvs_impulse (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_valid,
    input  logic [31:0]     i_len,
    input  dcvs_pkg::t_nvec i_n,
    input  dcvs_pkg::t_vel  i_vel,
    input  logic [30:0]     i_rest_length,
    input  logic [30:0]     i_inv_time_step,
    output logic            o_valid,
    output logic [31:0]     o_lam,
    output dcvs_pkg::t_nvec o_n,
    output dcvs_pkg::t_vel  o_vel
);

    localparam int unsigned LD = dcvs_pkg::LDIV_STEPS;

    typedef struct packed {
        dcvs_pkg::t_nvec n;
        dcvs_pkg::t_vel  vel;
    } t_side;

    typedef struct packed {
        t_side       sd;
        logic [31:0] wsum;
        logic [31:0] low;
        logic        neg;
        logic        ovf;
    } t_dside;

    logic                    r_1_vld;
    logic [2:0][32:0]        r_1_diff;
    logic signed [31:0]      r_1_err;
    t_side                   r_1_side;

    logic                    r_2_vld;
    logic signed [2:0][50:0] r_2_prod;
    logic signed [62:0]      r_2_bprod;
    t_side                   r_2_side;

    logic                    r_3_vld;
    logic signed [52:0]      r_3_acc;
    logic signed [31:0]      r_3_bias;
    t_side                   r_3_side;

    logic                    r_4_vld;
    logic signed [31:0]      r_4_vrel;
    logic signed [31:0]      r_4_bias;
    t_side                   r_4_side;

    logic                    r_5_vld;
    logic [32:0]             r_5_mag;
    logic                    r_5_neg;
    logic [31:0]             r_5_wsum;
    t_side                   r_5_side;

    logic                    r_6_vld;
    logic [31:0]             r_6_rem;
    t_dside                  r_6_side;

    logic                    r_d_vld  [LD];
    logic [31:0]             r_d_rem  [LD];
    logic [31:0]             r_d_quo  [LD];
    t_dside                  r_d_side [LD];

    logic                    r_o_vld;
    logic [31:0]             r_o_lam;
    t_side                   r_o_side;

    logic signed [33:0]      err_w;
    logic signed [33:0]      s_w;
    logic [31:0]             high_w;
    logic [31:0]             q_w;
    t_dside                  dq_w;

    assign err_w  = $signed({2'b00, i_len}) - $signed({3'b000, i_rest_length});
    assign s_w    = -34'(r_4_vrel) - 34'(r_4_bias);
    assign high_w = {15'd0, r_5_mag[32:16]};
    assign q_w    = r_d_quo[LD-1];
    assign dq_w   = r_d_side[LD-1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_1_vld <= 1'b0;
            r_2_vld <= 1'b0;
            r_3_vld <= 1'b0;
            r_4_vld <= 1'b0;
            r_5_vld <= 1'b0;
            r_6_vld <= 1'b0;
            r_o_vld <= 1'b0;
        end else begin
            r_1_vld <= i_valid;
            r_2_vld <= r_1_vld;
            r_3_vld <= r_2_vld;
            r_4_vld <= r_3_vld;
            r_5_vld <= r_4_vld;
            r_6_vld <= r_5_vld;
            r_o_vld <= r_d_vld[LD-1];
        end
    end

    always_ff @(posedge i_clk) begin
        for (int i = 0; i < 3; i++) begin
            r_1_diff[i] <= 33'($signed(i_vel.vb[i])) - 33'($signed(i_vel.va[i]));
        end
        r_1_err  <= dcvs_pkg::sat32(64'(err_w));
        r_1_side <= '{n: i_n, vel: i_vel};

        for (int i = 0; i < 3; i++) begin
            r_2_prod[i] <= $signed(r_1_side.n[i]) * $signed(r_1_diff[i]);
        end
        r_2_bprod <= r_1_err * $signed({1'b0, i_inv_time_step});
        r_2_side  <= r_1_side;

        r_3_acc  <= 53'($signed(r_2_prod[0])) + 53'($signed(r_2_prod[1]))
                    + 53'($signed(r_2_prod[2]));
        r_3_bias <= dcvs_pkg::sat32(64'(r_2_bprod >>> 16));
        r_3_side <= r_2_side;

        r_4_vrel <= dcvs_pkg::sat32(64'(r_3_acc >>> 16));
        r_4_bias <= r_3_bias;
        r_4_side <= r_3_side;

        r_5_neg  <= s_w[33];
        r_5_mag  <= s_w[33] ? 33'(-s_w) : 33'(s_w);
        r_5_wsum <= {1'b0, r_4_side.vel.wa} + {1'b0, r_4_side.vel.wb};
        r_5_side <= r_4_side;

        // quotient of 2^32 or more saturates; otherwise the top part seeds the remainder
        r_6_rem       <= high_w;
        r_6_side.ovf  <= high_w >= r_5_wsum;
        r_6_side.neg  <= r_5_neg;
        r_6_side.low  <= {r_5_mag[15:0], 16'd0};
        r_6_side.wsum <= r_5_wsum;
        r_6_side.sd   <= r_5_side;
    end

    genvar j;
    for (j = 0; j < LD; j++) begin : g_ld
        logic        vld_in;
        logic [31:0] rem_in;
        logic [31:0] quo_in;
        t_dside      sd_in;
        logic [32:0] cat;

        if (j == 0) begin : g_first
            assign vld_in = r_6_vld;
            assign rem_in = r_6_rem;
            assign quo_in = '0;
            assign sd_in  = r_6_side;
        end else begin : g_next
            assign vld_in = r_d_vld[j-1];
            assign rem_in = r_d_rem[j-1];
            assign quo_in = r_d_quo[j-1];
            assign sd_in  = r_d_side[j-1];
        end

        assign cat = {rem_in, sd_in.low[LD-1-j]};

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_d_vld[j] <= 1'b0;
            end else begin
                r_d_vld[j] <= vld_in;
            end
        end

        always_ff @(posedge i_clk) begin
            if (cat >= {1'b0, sd_in.wsum}) begin
                r_d_rem[j] <= 32'(cat - {1'b0, sd_in.wsum});
                r_d_quo[j] <= {quo_in[30:0], 1'b1};
            end else begin
                r_d_rem[j] <= 32'(cat);
                r_d_quo[j] <= {quo_in[30:0], 1'b0};
            end
            r_d_side[j] <= sd_in;
        end
    end

    always_ff @(posedge i_clk) begin
        if (dq_w.neg) begin
            if (dq_w.ovf || (q_w[31] && (|q_w[30:0]))) begin
                r_o_lam <= 32'h80000000;
            end else begin
                r_o_lam <= 32'(-q_w);
            end
        end else begin
            if (dq_w.ovf || q_w[31]) begin
                r_o_lam <= 32'h7fffffff;
            end else begin
                r_o_lam <= q_w;
            end
        end
        r_o_side <= dq_w.sd;
    end

    assign o_valid = r_o_vld;
    assign o_lam   = r_o_lam;
    assign o_n     = r_o_side.n;
    assign o_vel   = r_o_side.vel;

endmodule

// ----- rtl/dcvs_apply.sv -----
// Impulse vector and mass-weighted velocity update with saturation.
module dcvs_apply (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_valid,
    input  logic [31:0]     i_lam,
    input  dcvs_pkg::t_nvec i_n,
    input  dcvs_pkg::t_vel  i_vel,
    output logic            o_valid,
    output dcvs_pkg::t_vec3 o_va,
    output dcvs_pkg::t_vec3 o_vb,
    output logic            o_degen
);

    logic                    r_1_vld;
    logic signed [2:0][49:0] r_1_pl;
    dcvs_pkg::t_vel          r_1_vel;

    logic                    r_2_vld;
    dcvs_pkg::t_vec3         r_2_p;
    dcvs_pkg::t_vel          r_2_vel;

    logic                    r_3_vld;
    logic signed [2:0][62:0] r_3_pa;
    logic signed [2:0][62:0] r_3_pb;
    dcvs_pkg::t_vel          r_3_vel;

    logic                    r_4_vld;
    dcvs_pkg::t_vec3         r_4_va;
    dcvs_pkg::t_vec3         r_4_vb;
    logic                    r_4_degen;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_1_vld <= 1'b0;
            r_2_vld <= 1'b0;
            r_3_vld <= 1'b0;
            r_4_vld <= 1'b0;
        end else begin
            r_1_vld <= i_valid;
            r_2_vld <= r_1_vld;
            r_3_vld <= r_2_vld;
            r_4_vld <= r_3_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        for (int i = 0; i < 3; i++) begin
            r_1_pl[i] <= $signed(i_lam) * $signed(i_n[i]);
        end
        r_1_vel <= i_vel;

        for (int i = 0; i < 3; i++) begin
            r_2_p[i] <= dcvs_pkg::sat32(64'($signed(r_1_pl[i]) >>> 16));
        end
        r_2_vel <= r_1_vel;

        for (int i = 0; i < 3; i++) begin
            r_3_pa[i] <= $signed(r_2_p[i]) * $signed({1'b0, r_2_vel.wa});
            r_3_pb[i] <= $signed(r_2_p[i]) * $signed({1'b0, r_2_vel.wb});
        end
        r_3_vel <= r_2_vel;

        for (int i = 0; i < 3; i++) begin
            if (r_3_vel.degen) begin
                r_4_va[i] <= r_3_vel.va[i];
                r_4_vb[i] <= r_3_vel.vb[i];
            end else begin
                r_4_va[i] <= dcvs_pkg::sat32(64'($signed(r_3_vel.va[i]))
                                             - 64'($signed(r_3_pa[i]) >>> 16));
                r_4_vb[i] <= dcvs_pkg::sat32(64'($signed(r_3_vel.vb[i]))
                                             + 64'($signed(r_3_pb[i]) >>> 16));
            end
        end
        r_4_degen <= r_3_vel.degen;
    end

    assign o_valid = r_4_vld;
    assign o_va    = r_4_va;
    assign o_vb    = r_4_vb;
    assign o_degen = r_4_degen;

endmodule

// ----- bench/testbench.sv -----
// Testbench for distance_constraint_velocity_solve: directed, register sweep and random checks.
`timescale 1ns / 100ps

module testbench;

    localparam int LATENCY = 96;
    localparam int STALL_LIMIT = 4000;

    typedef struct {
        dcvs_pkg::t_vec3 d;
        dcvs_pkg::t_vec3 va;
        dcvs_pkg::t_vec3 vb;
        logic [30:0]     wa;
        logic [30:0]     wb;
    } t_constraint;

    typedef struct {
        dcvs_pkg::t_vec3 va;
        dcvs_pkg::t_vec3 vb;
        logic            degen;
    } t_solution;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        start = 1'b0;
    logic        busy;
    logic        i_cfg_we = 1'b0;
    logic        i_cfg_idx = dcvs_pkg::CFG_REST_LENGTH;
    logic [30:0] i_cfg_wdata = '0;
    logic [31:0] i_delta_x = '0, i_delta_y = '0, i_delta_z = '0;
    logic [31:0] i_vel_a_x = '0, i_vel_a_y = '0, i_vel_a_z = '0;
    logic [31:0] i_vel_b_x = '0, i_vel_b_y = '0, i_vel_b_z = '0;
    logic [30:0] i_inv_mass_a = '0, i_inv_mass_b = '0;
    logic        o_done;
    logic [31:0] o_new_vel_a_x, o_new_vel_a_y, o_new_vel_a_z;
    logic [31:0] o_new_vel_b_x, o_new_vel_b_y, o_new_vel_b_z;
    logic        o_degenerate;

    logic [30:0] rest_len_q = '0;
    logic [30:0] inv_dt_q = dcvs_pkg::ITS_RESET;
    t_solution   pending_solutions[$];
    int          errors = 0;
    int          items_sent = 0;
    int          results_seen = 0;
    int          degen_seen = 0;
    int          cfg_writes = 0;
    int          idle_cycles = 0;

    distance_constraint_velocity_solve uut (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .start(start), .busy(busy),
        .i_cfg_we(i_cfg_we), .i_cfg_idx(i_cfg_idx), .i_cfg_wdata(i_cfg_wdata),
        .i_delta_x(i_delta_x), .i_delta_y(i_delta_y), .i_delta_z(i_delta_z),
        .i_vel_a_x(i_vel_a_x), .i_vel_a_y(i_vel_a_y), .i_vel_a_z(i_vel_a_z),
        .i_vel_b_x(i_vel_b_x), .i_vel_b_y(i_vel_b_y), .i_vel_b_z(i_vel_b_z),
        .i_inv_mass_a(i_inv_mass_a), .i_inv_mass_b(i_inv_mass_b),
        .o_done(o_done),
        .o_new_vel_a_x(o_new_vel_a_x), .o_new_vel_a_y(o_new_vel_a_y),
        .o_new_vel_a_z(o_new_vel_a_z), .o_new_vel_b_x(o_new_vel_b_x),
        .o_new_vel_b_y(o_new_vel_b_y), .o_new_vel_b_z(o_new_vel_b_z),
        .o_degenerate(o_degenerate)
    );

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    function automatic longint clamp32(input longint x);
        if (x > 64'sd2147483647) return 64'sd2147483647;
        if (x < -64'sd2147483648) return -64'sd2147483648;
        return x;
    endfunction

    function automatic longint unsigned int_sqrt(input longint unsigned v);
        longint unsigned root, bitv;
        root = 0;
        bitv = 64'd1 << 62;
        while (bitv > v) bitv >>= 2;
        while (bitv != 0) begin
            if (v >= root + bitv) begin
                v -= root + bitv;
                root = (root >> 1) + bitv;
            end else begin
                root >>= 1;
            end
            bitv >>= 2;
        end
        return root;
    endfunction

    function automatic t_solution solve_constraint(input t_constraint c);
        longint d[3], va[3], vb[3], nrm[3];
        longint unsigned sq, len, wsum;
        longint acc, vrel, err, bias, lam, p, wa, wb, r;
        t_solution s;
        s.va = c.va;
        s.vb = c.vb;
        sq = 0;
        for (int i = 0; i < 3; i++) begin
            d[i] = longint'($signed(c.d[i]));
            va[i] = longint'($signed(c.va[i]));
            vb[i] = longint'($signed(c.vb[i]));
            sq += longint'(d[i] * d[i]);
        end
        wa = longint'(c.wa);
        wb = longint'(c.wb);
        len = int_sqrt(sq);
        wsum = c.wa + 64'd0 + c.wb;
        s.degen = (len == 0) || (wsum == 0);
        if (!s.degen) begin
            acc = 0;
            for (int i = 0; i < 3; i++) begin
                nrm[i] = (d[i] * 65536) / longint'(len);
                acc += nrm[i] * (vb[i] - va[i]);
            end
            vrel = clamp32(acc >>> 16);
            err = clamp32(longint'(len) - longint'(rest_len_q));
            bias = clamp32((err * longint'(inv_dt_q)) >>> 16);
            lam = clamp32(((-vrel - bias) * 65536) / longint'(wsum));
            for (int i = 0; i < 3; i++) begin
                p = clamp32((lam * nrm[i]) >>> 16);
                r = clamp32(va[i] - ((p * wa) >>> 16));
                s.va[i] = r[31:0];
                r = clamp32(vb[i] + ((p * wb) >>> 16));
                s.vb[i] = r[31:0];
            end
        end
        return s;
    endfunction

    function automatic logic [31:0] pick_word();
        case ($urandom_range(0, 9))
            0: return 32'h0;
            1: return 32'h7fffffff;
            2: return 32'h80000000;
            3, 4, 5: return $urandom_range(0, 32'h000fffff) - 32'h00080000;
            6: return $urandom_range(0, 32'h0fffffff) - 32'h08000000;
            default: return $urandom;
        endcase
    endfunction

    function automatic logic [30:0] pick_mass();
        case ($urandom_range(0, 9))
            0: return 31'h0;
            1: return 31'h7fffffff;
            2, 3, 4, 5: return 31'($urandom_range(0, 32'h0003ffff));
            default: return 31'($urandom);
        endcase
    endfunction

    function automatic t_constraint random_constraint();
        t_constraint c;
        for (int i = 0; i < 3; i++) begin
            c.d[i] = pick_word();
            c.va[i] = pick_word();
            c.vb[i] = pick_word();
        end
        c.wa = pick_mass();
        c.wb = pick_mass();
        return c;
    endfunction

    function automatic t_constraint make_constraint(input logic [31:0] dv, vav, vbv,
                                                    input logic [30:0] wa, wb);
        t_constraint c;
        for (int i = 0; i < 3; i++) begin
            c.d[i] = dv;
            c.va[i] = vav;
            c.vb[i] = vbv;
        end
        c.wa = wa;
        c.wb = wb;
        return c;
    endfunction

    task automatic send_constraint(input t_constraint c, input int gap);
        start <= 1'b1;
        {i_delta_x, i_delta_y, i_delta_z} <= {c.d[0], c.d[1], c.d[2]};
        {i_vel_a_x, i_vel_a_y, i_vel_a_z} <= {c.va[0], c.va[1], c.va[2]};
        {i_vel_b_x, i_vel_b_y, i_vel_b_z} <= {c.vb[0], c.vb[1], c.vb[2]};
        i_inv_mass_a <= c.wa;
        i_inv_mass_b <= c.wb;
        @(posedge i_clk);
        while (busy) @(posedge i_clk);
        pending_solutions.push_back(solve_constraint(c));
        items_sent++;
        idle_cycles = 0;
        if (gap > 0) begin
            start <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
    endtask

    function automatic int random_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 90) return $urandom_range(1, 3);
        return $urandom_range(4, 120);
    endfunction

    task automatic drain();
        start <= 1'b0;
        @(posedge i_clk);
        while (pending_solutions.size() != 0) @(posedge i_clk);
        repeat (LATENCY + 4) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic idx, input logic [30:0] value);
        drain();
        i_cfg_we <= 1'b1;
        i_cfg_idx <= idx;
        i_cfg_wdata <= value;
        @(posedge i_clk);
        if (idx == dcvs_pkg::CFG_REST_LENGTH) rest_len_q = value;
        else inv_dt_q = value;
        cfg_writes++;
        i_cfg_we <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic test_directed();
        t_constraint c;
        send_constraint(make_constraint(32'h0, 32'h00010000, 32'hffff0000,
                                        31'h10000, 31'h10000), 0);
        send_constraint(make_constraint(32'h00010000, 32'h00020000, 32'h0,
                                        31'h0, 31'h0), 1);
        send_constraint(make_constraint(32'h00010000, 32'h00020000, 32'h0,
                                        31'h10000, 31'h10000), 0);
        send_constraint(make_constraint(32'h7fffffff, 32'h80000000, 32'h7fffffff,
                                        31'h7fffffff, 31'h7fffffff), 0);
        send_constraint(make_constraint(32'h80000000, 32'h7fffffff, 32'h80000000,
                                        31'h7fffffff, 31'h0), 2);
        send_constraint(make_constraint(32'h80000000, 32'h80000000, 32'h7fffffff,
                                        31'h0, 31'h1), 0);
        send_constraint(make_constraint(32'hffffffff, 32'hffffffff, 32'h1,
                                        31'h1, 31'h0), 0);
        send_constraint(make_constraint(32'h00000001, 32'h0, 32'h0,
                                        31'h10000, 31'h0), 3);
        c = make_constraint(32'h0, 32'h12345678, 32'hedcba987, 31'h0, 31'h0);
        c.d[1] = 32'h00030000;
        send_constraint(c, 0);
        c = make_constraint(32'h0, 32'h80000000, 32'h7fffffff, 31'h7fffffff, 31'h7fffffff);
        c.d[2] = 32'h80000000;
        send_constraint(c, 0);
        c = make_constraint(32'h00008000, 32'hfff00000, 32'h00100000, 31'h8000, 31'h20000);
        c.d[0] = 32'hffff8000;
        send_constraint(c, 0);
        for (int i = 0; i < 8; i++) send_constraint(random_constraint(), i % 2);
    endtask

    task automatic test_register_sweep();
        logic [30:0] rest_vals[4];
        logic [30:0] dt_vals[4];
        rest_vals = '{31'h0, 31'h7fffffff, 31'h00010000, 31'h0};
        dt_vals = '{31'h0, 31'h7fffffff, 31'h00000001, dcvs_pkg::ITS_RESET};
        for (int k = 0; k < 4; k++) begin
            write_reg(dcvs_pkg::CFG_REST_LENGTH, rest_vals[k]);
            write_reg(dcvs_pkg::CFG_INV_TIME_STEP, dt_vals[k]);
            for (int i = 0; i < 40; i++) send_constraint(random_constraint(), random_gap());
        end
    endtask

    task automatic test_random_stream();
        for (int phase = 0; phase < 6; phase++) begin
            write_reg(dcvs_pkg::CFG_REST_LENGTH,
                      (phase % 2) ? 31'($urandom) : 31'($urandom_range(0, 32'h00ffffff)));
            write_reg(dcvs_pkg::CFG_INV_TIME_STEP,
                      (phase % 3 == 0) ? dcvs_pkg::ITS_RESET : 31'($urandom));
            for (int i = 0; i < 290; i++) send_constraint(random_constraint(), random_gap());
        end
        drain();
    endtask

    always @(posedge i_clk) begin
        t_solution s;
        dcvs_pkg::t_vec3 ga, gb;
        if (i_rst_n && o_done) begin
            results_seen++;
            idle_cycles = 0;
            ga = {o_new_vel_a_z, o_new_vel_a_y, o_new_vel_a_x};
            gb = {o_new_vel_b_z, o_new_vel_b_y, o_new_vel_b_x};
            if (pending_solutions.size() == 0) begin
                $display("%0t: result transfer with nothing expected", $time);
                errors++;
            end else begin
                s = pending_solutions.pop_front();
                if (s.degen) degen_seen++;
                for (int i = 0; i < 3; i++) begin
                    if (ga[i] !== s.va[i]) begin
                        $display("%0t: new_vel_a[%0d] expected %h actual %h",
                                 $time, i, s.va[i], ga[i]);
                        errors++;
                    end
                    if (gb[i] !== s.vb[i]) begin
                        $display("%0t: new_vel_b[%0d] expected %h actual %h",
                                 $time, i, s.vb[i], gb[i]);
                        errors++;
                    end
                end
                if (o_degenerate !== s.degen) begin
                    $display("%0t: degenerate expected %b actual %b",
                             $time, s.degen, o_degenerate);
                    errors++;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        idle_cycles++;
        if (idle_cycles > STALL_LIMIT) begin
            $display("%0t: timeout, no transfer for %0d cycles", $time, STALL_LIMIT);
            $display("status: fail");
            $finish;
        end
    end

    initial begin
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_directed();
        test_register_sweep();
        test_random_stream();
        $display("Sent %0d constraints, checked %0d results (%0d degenerate).",
                 items_sent, results_seen, degen_seen);
        $display("%0d register writes, %0d mismatches.", cfg_writes, errors);
        if (errors == 0 && pending_solutions.size() == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

endmodule

// ----- filelist.f -----
rtl/dcvs_pkg.sv
rtl/dcvs_norm.sv
rtl/dcvs_impulse.sv
rtl/dcvs_apply.sv
rtl/distance_constraint_velocity_solve.sv
bench/testbench.sv
